>>> rtl/perspective_vertex_projector_unit_defines.svh
// assertion macros for the perspective vertex projector
// used by the top level only; no other dependencies
`ifndef PERSPECTIVE_VERTEX_PROJECTOR_UNIT_DEFINES_SVH
`define PERSPECTIVE_VERTEX_PROJECTOR_UNIT_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define PVP_ASSERT_IMPLY(label, clk, rstn, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (cond) |-> (prop)) \
        else $error("pvp assertion failed");
`define PVP_ASSERT_NEXT(label, clk, rstn, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (cond) |=> (prop)) \
        else $error("pvp assertion failed");
`else
`define PVP_ASSERT_IMPLY(label, clk, rstn, cond, prop)
`define PVP_ASSERT_NEXT(label, clk, rstn, cond, prop)
`endif
`endif

>>> rtl/pvp_pkg.sv
// shared types, widths and constants of the perspective vertex projector
// no dependencies
`default_nettype none
package pvp_pkg;
    localparam int COORD_WIDTH   = 16;
    localparam int FRAC_BITS     = 14;
    localparam int TRIG_WIDTH    = 16;
    localparam int CFG_WIDTH     = 16;
    localparam int ORG_WIDTH     = 10;
    localparam int CFG_IDX_WIDTH = 3;

    localparam int PROD_WIDTH = COORD_WIDTH + TRIG_WIDTH;
    localparam int A_WIDTH    = PROD_WIDTH + 1;
    localparam int AT_WIDTH   = A_WIDTH + TRIG_WIDTH;
    localparam int EYE_WIDTH  = 48;
    localparam int SUM_WIDTH  = (AT_WIDTH - FRAC_BITS + 2 > EYE_WIDTH + 1) ?
                                (AT_WIDTH - FRAC_BITS + 2) : (EYE_WIDTH + 1);

    localparam int MAG_WIDTH  = EYE_WIDTH;
    localparam int NUM_WIDTH  = MAG_WIDTH + CFG_WIDTH;
    localparam int QUOT_BITS  = 41;
    localparam int PROJ_WIDTH = QUOT_BITS + 1;
    localparam int SCR_WIDTH  = PROJ_WIDTH + 1;

    localparam int EYE_LAT   = 4;
    localparam int DIV_LAT   = QUOT_BITS + 4;
    localparam int PIPE_LAT  = EYE_LAT + DIV_LAT;

    typedef enum logic [CFG_IDX_WIDTH-1:0] {
        REG_SIN_THETA       = 3'd0,
        REG_COS_THETA       = 3'd1,
        REG_SIN_PHI         = 3'd2,
        REG_COS_PHI         = 3'd3,
        REG_EYE_DISTANCE    = 3'd4,
        REG_SCREEN_DISTANCE = 3'd5,
        REG_ORIGIN_X        = 3'd6,
        REG_ORIGIN_Y        = 3'd7
    } cfg_reg_t;

    localparam logic signed [TRIG_WIDTH-1:0] RST_SIN_THETA       = 16'sd10555;
    localparam logic signed [TRIG_WIDTH-1:0] RST_COS_THETA       = 16'sd12531;
    localparam logic signed [TRIG_WIDTH-1:0] RST_SIN_PHI         = 16'sd12834;
    localparam logic signed [TRIG_WIDTH-1:0] RST_COS_PHI         = 16'sd10185;
    localparam logic signed [CFG_WIDTH-1:0]  RST_EYE_DISTANCE    = 16'sd40;
    localparam logic signed [CFG_WIDTH-1:0]  RST_SCREEN_DISTANCE = 16'sd250;
    localparam logic [ORG_WIDTH-1:0]         RST_ORIGIN_X        = 10'd320;
    localparam logic [ORG_WIDTH-1:0]         RST_ORIGIN_Y        = 10'd150;

    typedef struct packed {
        logic signed [TRIG_WIDTH-1:0] sin_theta;
        logic signed [TRIG_WIDTH-1:0] cos_theta;
        logic signed [TRIG_WIDTH-1:0] sin_phi;
        logic signed [TRIG_WIDTH-1:0] cos_phi;
        logic signed [CFG_WIDTH-1:0]  eye_distance;
        logic signed [CFG_WIDTH-1:0]  screen_distance;
        logic [ORG_WIDTH-1:0]         origin_x;
        logic [ORG_WIDTH-1:0]         origin_y;
    } cfg_t;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] vertex_x;
        logic signed [COORD_WIDTH-1:0] vertex_y;
        logic signed [COORD_WIDTH-1:0] vertex_z;
    } vertex_t;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] screen_x;
        logic signed [COORD_WIDTH-1:0] screen_y;
        logic                          depth_zero;
    } result_t;

    typedef struct packed {
        logic signed [EYE_WIDTH-1:0] xe;
        logic signed [EYE_WIDTH-1:0] ye;
        logic signed [EYE_WIDTH-1:0] ze;
    } eye_t;
endpackage
`default_nettype wire

>>> rtl/pvp_eye.sv
// eye coordinate pipeline: four register stages from world vertex to xe, ye, ze
// depends on pvp_pkg
`default_nettype none
module pvp_eye (
    input  wire logic            aclk,
    input  wire logic            en,
    input  wire pvp_pkg::cfg_t    cfg,
    input  wire pvp_pkg::vertex_t vin,
    output pvp_pkg::eye_t         eye
);
    localparam int PW = pvp_pkg::PROD_WIDTH;
    localparam int AW = pvp_pkg::A_WIDTH;
    localparam int TW = pvp_pkg::AT_WIDTH;
    localparam int SW = pvp_pkg::SUM_WIDTH;
    localparam int EW = pvp_pkg::EYE_WIDTH;

    function automatic logic signed [EW-1:0] sat_eye(input logic signed [SW-1:0] v);
        logic same;
        same = (v[SW-1:EW-1] == '0) || (v[SW-1:EW-1] == '1);
        if (same) begin
            return v[EW-1:0];
        end else if (v[SW-1]) begin
            return {1'b1, {(EW-1){1'b0}}};
        end else begin
            return {1'b0, {(EW-1){1'b1}}};
        end
    endfunction

    logic signed [PW-1:0] xc_reg, xs_reg, yc_reg, ys_reg, zs_reg, zc_reg;
    logic signed [PW-1:0] zs2_reg, zc2_reg, zs3_reg, zc3_reg;
    logic signed [AW-1:0] a_reg, xe2_reg, xe3_reg;
    logic signed [TW-1:0] ac_reg, as_reg;
    logic signed [SW-1:0] xe_next, ye_next, ze_next;
    pvp_pkg::eye_t        eye_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            xc_reg  <= vin.vertex_x * cfg.cos_theta;
            xs_reg  <= vin.vertex_x * cfg.sin_theta;
            yc_reg  <= vin.vertex_y * cfg.cos_theta;
            ys_reg  <= vin.vertex_y * cfg.sin_theta;
            zs_reg  <= vin.vertex_z * cfg.sin_phi;
            zc_reg  <= vin.vertex_z * cfg.cos_phi;

            a_reg   <= -AW'(xc_reg) - AW'(ys_reg);
            xe2_reg <= -AW'(xs_reg) + AW'(yc_reg);
            zs2_reg <= zs_reg;
            zc2_reg <= zc_reg;

            ac_reg  <= a_reg * cfg.cos_phi;
            as_reg  <= a_reg * cfg.sin_phi;
            xe3_reg <= xe2_reg;
            zs3_reg <= zs2_reg;
            zc3_reg <= zc2_reg;

            eye_reg.xe <= sat_eye(xe_next);
            eye_reg.ye <= sat_eye(ye_next);
            eye_reg.ze <= sat_eye(ze_next);
        end
    end

    always_comb begin
        xe_next = SW'(xe3_reg);
        ye_next = SW'(ac_reg >>> pvp_pkg::FRAC_BITS) + SW'(zs3_reg);
        ze_next = SW'(as_reg >>> pvp_pkg::FRAC_BITS) - SW'(zc3_reg)
                + (SW'(cfg.eye_distance) <<< pvp_pkg::FRAC_BITS);
    end

    assign eye = eye_reg;
endmodule
`default_nettype wire

>>> rtl/pvp_div.sv
// projection lane: scales one eye coordinate by the screen distance and divides by depth
// one quotient bit per bit stage; depends on pvp_pkg
`default_nettype none
module pvp_div (
    input  wire logic                                aclk,
    input  wire logic                                en,
    input  wire logic signed [pvp_pkg::EYE_WIDTH-1:0] e,
    input  wire logic signed [pvp_pkg::EYE_WIDTH-1:0] ze,
    input  wire logic signed [pvp_pkg::CFG_WIDTH-1:0] sd,
    output logic signed [pvp_pkg::PROJ_WIDTH-1:0]     p
);
    localparam int MW = pvp_pkg::MAG_WIDTH;
    localparam int NW = pvp_pkg::NUM_WIDTH;
    localparam int QB = pvp_pkg::QUOT_BITS;
    localparam int CW = pvp_pkg::CFG_WIDTH;
    localparam int HW = NW - QB;
    localparam logic [QB-1:0] Q_CAP = {1'b1, {(QB-1){1'b0}}};

    logic [MW-1:0] mag_e_reg, mag_z_reg, den1_reg;
    logic [CW-1:0] mag_sd_reg;
    logic          neg0_reg, neg1_reg;
    logic [NW-1:0] num_reg;

    logic [MW-1:0] rem_reg [QB];
    logic [QB-1:0] low_reg [QB];
    logic [MW-1:0] den_reg [QB];
    logic [QB-1:0] q_reg   [QB+1];
    logic          neg_reg [QB+1];
    logic          ovf_reg [QB+1];

    logic [QB-1:0] q_cap;
    logic signed [pvp_pkg::PROJ_WIDTH-1:0] p_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            mag_e_reg  <= e[MW-1] ? MW'(-e) : MW'(e);
            mag_z_reg  <= ze[MW-1] ? MW'(-ze) : MW'(ze);
            mag_sd_reg <= sd[CW-1] ? CW'(-sd) : CW'(sd);
            neg0_reg   <= e[MW-1] ^ sd[CW-1] ^ ze[MW-1];

            num_reg  <= NW'(mag_sd_reg) * NW'(mag_e_reg);
            den1_reg <= mag_z_reg;
            neg1_reg <= neg0_reg;

            // a high part at or above the divisor means the quotient is past the cap
            ovf_reg[0] <= MW'(num_reg[NW-1:QB]) >= den1_reg;
            rem_reg[0] <= MW'(num_reg[NW-1:QB]);
            low_reg[0] <= num_reg[QB-1:0];
            den_reg[0] <= den1_reg;
            q_reg[0]   <= '0;
            neg_reg[0] <= neg1_reg;
        end
    end

    for (genvar k = 0; k < QB; k++) begin : g_bit
        logic [MW:0] trial, diff;
        logic        take;
        assign trial = {rem_reg[k], low_reg[k][QB-1]};
        assign diff  = trial - {1'b0, den_reg[k]};
        assign take  = trial >= {1'b0, den_reg[k]};

        always_ff @(posedge aclk) begin
            if (en) begin
                q_reg[k+1]   <= {q_reg[k][QB-2:0], take};
                neg_reg[k+1] <= neg_reg[k];
                ovf_reg[k+1] <= ovf_reg[k];
            end
        end

        if (k < QB - 1) begin : g_carry
            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[k+1] <= take ? diff[MW-1:0] : trial[MW-1:0];
                    low_reg[k+1] <= {low_reg[k][QB-2:0], 1'b0};
                    den_reg[k+1] <= den_reg[k];
                end
            end
        end
    end

    always_comb begin
        q_cap = (ovf_reg[QB] || (q_reg[QB] > Q_CAP)) ? Q_CAP : q_reg[QB];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p_reg <= neg_reg[QB] ? -$signed(pvp_pkg::PROJ_WIDTH'(q_cap))
                                 : $signed(pvp_pkg::PROJ_WIDTH'(q_cap));
        end
    end

    assign p = p_reg;
endmodule
`default_nettype wire

>>> rtl/perspective_vertex_projector_unit.sv
// perspective vertex projector: one world vertex in, one screen position out
// depends on pvp_pkg, pvp_eye, pvp_div and the assertion macro header
//
// usage:
//   s_valid/s_ready/s_data carry one vertex request (x, y, z) per cycle if not stalled.
//   m_valid/m_ready/m_data return screen_x, screen_y and depth_zero in order.
//   cfg_we/cfg_idx/cfg_wdata write one register a cycle, no wait, while idle.
// pipeline: four stages form the eye coordinates, then each lane runs a 45 stage
//   divider, one quotient bit per bit stage, then one output stage.
// throughput: one request per cycle while no stall holds the pipeline;
//   the two divider lanes set the depth.
// reset: clears every valid bit and loads the default view registers;
//   no clearing pass.
// stall: while a result waits on m_ready the whole pipeline holds,
//   s_ready drops, and nothing is lost or repeated.
`default_nettype none
`include "perspective_vertex_projector_unit_defines.svh"
module perspective_vertex_projector_unit (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 s_valid,
    output logic                                      s_ready,
    input  wire pvp_pkg::vertex_t                     s_data,
    output logic                                      m_valid,
    input  wire logic                                 m_ready,
    output pvp_pkg::result_t                          m_data,
    input  wire logic                                 cfg_we,
    input  wire logic [pvp_pkg::CFG_IDX_WIDTH-1:0]    cfg_idx,
    input  wire logic [pvp_pkg::CFG_WIDTH-1:0]        cfg_wdata
);
    localparam int CW = pvp_pkg::COORD_WIDTH;
    localparam int SW = pvp_pkg::SCR_WIDTH;
    localparam int PW = pvp_pkg::PROJ_WIDTH;
    localparam int NL = pvp_pkg::PIPE_LAT;
    localparam int DL = pvp_pkg::DIV_LAT;

    function automatic logic signed [CW-1:0] sat_out(input logic signed [SW-1:0] v);
        if ((v[SW-1:CW-1] == '0) || (v[SW-1:CW-1] == '1)) begin
            return v[CW-1:0];
        end else if (v[SW-1]) begin
            return {1'b1, {(CW-1){1'b0}}};
        end else begin
            return {1'b0, {(CW-1){1'b1}}};
        end
    endfunction

    pvp_pkg::cfg_t    cfg_reg;
    pvp_pkg::eye_t    eye;
    pvp_pkg::result_t m_data_reg, m_data_next;
    logic             m_valid_reg;
    logic             en;
    logic [NL-1:0]    v_reg;
    logic [DL-1:0]    z_reg;
    logic signed [PW-1:0] px, py, px_eff, py_eff;

    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.sin_theta       <= pvp_pkg::RST_SIN_THETA;
            cfg_reg.cos_theta       <= pvp_pkg::RST_COS_THETA;
            cfg_reg.sin_phi         <= pvp_pkg::RST_SIN_PHI;
            cfg_reg.cos_phi         <= pvp_pkg::RST_COS_PHI;
            cfg_reg.eye_distance    <= pvp_pkg::RST_EYE_DISTANCE;
            cfg_reg.screen_distance <= pvp_pkg::RST_SCREEN_DISTANCE;
            cfg_reg.origin_x        <= pvp_pkg::RST_ORIGIN_X;
            cfg_reg.origin_y        <= pvp_pkg::RST_ORIGIN_Y;
        end else if (cfg_we) begin
            case (pvp_pkg::cfg_reg_t'(cfg_idx))
                pvp_pkg::REG_SIN_THETA:       cfg_reg.sin_theta       <= cfg_wdata;
                pvp_pkg::REG_COS_THETA:       cfg_reg.cos_theta       <= cfg_wdata;
                pvp_pkg::REG_SIN_PHI:         cfg_reg.sin_phi         <= cfg_wdata;
                pvp_pkg::REG_COS_PHI:         cfg_reg.cos_phi         <= cfg_wdata;
                pvp_pkg::REG_EYE_DISTANCE:    cfg_reg.eye_distance    <= cfg_wdata;
                pvp_pkg::REG_SCREEN_DISTANCE: cfg_reg.screen_distance <= cfg_wdata;
                pvp_pkg::REG_ORIGIN_X:
                    cfg_reg.origin_x <= cfg_wdata[pvp_pkg::ORG_WIDTH-1:0];
                pvp_pkg::REG_ORIGIN_Y:
                    cfg_reg.origin_y <= cfg_wdata[pvp_pkg::ORG_WIDTH-1:0];
                default: begin
                end
            endcase
        end
    end

    pvp_eye u_eye (
        .aclk (aclk),
        .en   (en),
        .cfg  (cfg_reg),
        .vin  (s_data),
        .eye  (eye)
    );

    pvp_div u_div_x (
        .aclk (aclk),
        .en   (en),
        .e    (eye.xe),
        .ze   (eye.ze),
        .sd   (cfg_reg.screen_distance),
        .p    (px)
    );

    pvp_div u_div_y (
        .aclk (aclk),
        .en   (en),
        .e    (eye.ye),
        .ze   (eye.ze),
        .sd   (cfg_reg.screen_distance),
        .p    (py)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg       <= '0;
            m_valid_reg <= 1'b0;
        end else if (en) begin
            v_reg       <= {v_reg[NL-2:0], s_valid};
            m_valid_reg <= v_reg[NL-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            z_reg      <= {z_reg[DL-2:0], (eye.ze == '0)};
            m_data_reg <= m_data_next;
        end
    end

    always_comb begin
        px_eff = z_reg[DL-1] ? '0 : px;
        py_eff = z_reg[DL-1] ? '0 : py;
        m_data_next.screen_x   = sat_out(SW'($signed({1'b0, cfg_reg.origin_x})) + SW'(px_eff));
        m_data_next.screen_y   = sat_out(SW'($signed({1'b0, cfg_reg.origin_y})) - SW'(py_eff));
        m_data_next.depth_zero = z_reg[DL-1];
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // stalled last stage keeps its request
    `PVP_ASSERT_NEXT(a_hold_last, aclk, aresetn, v_reg[NL-1] && !en, v_reg[NL-1])
    // an accepted request enters the first stage
    `PVP_ASSERT_NEXT(a_enter, aclk, aresetn, s_valid && s_ready, v_reg[0])
    // a zero depth result sits at the origin, which is never negative
    `PVP_ASSERT_IMPLY(a_zero_origin, aclk, aresetn, m_valid && m_data.depth_zero,
                      !m_data.screen_x[CW-1] && !m_data.screen_y[CW-1])
endmodule
`default_nettype wire

>>> dv/perspective_vertex_projector_unit_tb.sv
// testbench for perspective_vertex_projector_unit: random and directed vertex requests
// checked against an in-bench projection model; depends on pvp_pkg and the rtl only
`timescale 1ns / 100ps
module perspective_vertex_projector_unit_tb;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam longint EYE_HI = 64'sd140737488355327;
    localparam longint EYE_LO = -64'sd140737488355328;
    localparam longint unsigned QUOT_CAP = 64'd1 << 40;

    logic    aclk;
    logic    aresetn;
    logic    s_valid;
    logic    s_ready;
    pvp_pkg::vertex_t s_data;
    logic    m_valid;
    logic    m_ready;
    pvp_pkg::result_t m_data;
    logic    cfg_we;
    logic [pvp_pkg::CFG_IDX_WIDTH-1:0] cfg_idx;
    logic [pvp_pkg::CFG_WIDTH-1:0]     cfg_wdata;

    pvp_pkg::cfg_t    view;
    pvp_pkg::result_t expected_screen[$];
    int      mismatch_count;
    int      idle_cycles;
    bit      idle_on;
    int      stall_left;

    perspective_vertex_projector_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    function automatic longint clamp_eye(longint v);
        if (v > EYE_HI) return EYE_HI;
        if (v < EYE_LO) return EYE_LO;
        return v;
    endfunction

    function automatic logic [pvp_pkg::COORD_WIDTH-1:0] clamp_coord(longint v);
        longint hi;
        longint lo;
        hi = (64'sd1 <<< (pvp_pkg::COORD_WIDTH - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) return hi[pvp_pkg::COORD_WIDTH-1:0];
        if (v < lo) return lo[pvp_pkg::COORD_WIDTH-1:0];
        return v[pvp_pkg::COORD_WIDTH-1:0];
    endfunction

    function automatic longint unsigned magnitude(longint v);
        return (v < 0) ? longint'(-v) : longint'(v);
    endfunction

    // screen_distance * e / ze, truncated toward zero, magnitude capped
    function automatic longint scaled_quotient(longint e, longint ze);
        longint sd;
        longint unsigned q;
        bit neg;
        sd = view.screen_distance;
        neg = (e < 0) != (sd < 0);
        q = (magnitude(sd) * magnitude(e)) / magnitude(ze);
        if (ze < 0) neg = !neg;
        if (q > QUOT_CAP) q = QUOT_CAP;
        return neg ? -longint'(q) : longint'(q);
    endfunction

    function automatic pvp_pkg::result_t predict_screen(pvp_pkg::vertex_t v);
        longint x, y, z, st, ct, sp, cp, ed, ox, oy, a, xe, ye, ze;
        pvp_pkg::result_t r;
        x = v.vertex_x;
        y = v.vertex_y;
        z = v.vertex_z;
        st = view.sin_theta;
        ct = view.cos_theta;
        sp = view.sin_phi;
        cp = view.cos_phi;
        ed = view.eye_distance;
        ox = longint'(view.origin_x);
        oy = longint'(view.origin_y);
        a  = -x * ct - y * st;
        xe = clamp_eye(-x * st + y * ct);
        ye = clamp_eye(((a * cp) >>> pvp_pkg::FRAC_BITS) + z * sp);
        ze = clamp_eye(((a * sp) >>> pvp_pkg::FRAC_BITS) - z * cp
                       + ed * (64'sd1 <<< pvp_pkg::FRAC_BITS));
        if (ze == 0) begin
            r.depth_zero = 1'b1;
            r.screen_x = clamp_coord(ox);
            r.screen_y = clamp_coord(oy);
        end else begin
            r.depth_zero = 1'b0;
            r.screen_x = clamp_coord(ox + scaled_quotient(xe, ze));
            r.screen_y = clamp_coord(oy - scaled_quotient(ye, ze));
        end
        return r;
    endfunction

    // result channel stalls
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(1, 12) - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        pvp_pkg::result_t exp_r;
        if (aresetn && m_valid && m_ready) begin
            if (expected_screen.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result x=%0d y=%0d zero=%0b",
                             m_data.screen_x, m_data.screen_y, m_data.depth_zero);
            end else begin
                exp_r = expected_screen.pop_front();
                if (exp_r.screen_x !== m_data.screen_x) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("screen_x mismatch: expected %0d, got %0d",
                                 exp_r.screen_x, m_data.screen_x);
                end
                if (exp_r.screen_y !== m_data.screen_y) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("screen_y mismatch: expected %0d, got %0d",
                                 exp_r.screen_y, m_data.screen_y);
                end
                if (exp_r.depth_zero !== m_data.depth_zero) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("depth_zero mismatch: expected %0b, got %0b",
                                 exp_r.depth_zero, m_data.depth_zero);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[perspective_vertex_projector_unit] ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_vertex(input pvp_pkg::vertex_t v);
        int gap;
        if (idle_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 12);
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid <= 1'b1;
        s_data  <= v;
        do @(posedge aclk); while (!s_ready);
        expected_screen.push_back(predict_screen(v));
    endtask

    task automatic send_xyz(input int x, input int y, input int z);
        pvp_pkg::vertex_t v;
        v.vertex_x = x[pvp_pkg::COORD_WIDTH-1:0];
        v.vertex_y = y[pvp_pkg::COORD_WIDTH-1:0];
        v.vertex_z = z[pvp_pkg::COORD_WIDTH-1:0];
        send_vertex(v);
    endtask

    // hold off requests until every result is back
    task automatic drain_pipeline();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_screen.size() != 0) @(posedge aclk);
        repeat (pvp_pkg::PIPE_LAT + 10) @(negedge aclk);
    endtask

    task automatic write_reg(input pvp_pkg::cfg_reg_t r,
                             input logic [pvp_pkg::CFG_WIDTH-1:0] val);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_idx   <= r;
        cfg_wdata <= val;
        case (r)
            pvp_pkg::REG_SIN_THETA:       view.sin_theta = val;
            pvp_pkg::REG_COS_THETA:       view.cos_theta = val;
            pvp_pkg::REG_SIN_PHI:         view.sin_phi = val;
            pvp_pkg::REG_COS_PHI:         view.cos_phi = val;
            pvp_pkg::REG_EYE_DISTANCE:    view.eye_distance = val;
            pvp_pkg::REG_SCREEN_DISTANCE: view.screen_distance = val;
            pvp_pkg::REG_ORIGIN_X:        view.origin_x = val[pvp_pkg::ORG_WIDTH-1:0];
            pvp_pkg::REG_ORIGIN_Y:        view.origin_y = val[pvp_pkg::ORG_WIDTH-1:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic write_view(input int st, input int ct, input int sp, input int cp,
                              input int ed, input int sd, input int ox, input int oy);
        drain_pipeline();
        write_reg(pvp_pkg::REG_SIN_THETA, st[15:0]);
        write_reg(pvp_pkg::REG_COS_THETA, ct[15:0]);
        write_reg(pvp_pkg::REG_SIN_PHI, sp[15:0]);
        write_reg(pvp_pkg::REG_COS_PHI, cp[15:0]);
        write_reg(pvp_pkg::REG_EYE_DISTANCE, ed[15:0]);
        write_reg(pvp_pkg::REG_SCREEN_DISTANCE, sd[15:0]);
        write_reg(pvp_pkg::REG_ORIGIN_X, ox[15:0]);
        write_reg(pvp_pkg::REG_ORIGIN_Y, oy[15:0]);
    endtask

    function automatic int rand_coord();
        case ($urandom_range(0, 3))
            0: return $signed($urandom_range(0, 65535) - 32768);
            1: return $urandom_range(0, 255) - 128;
            2: case ($urandom_range(0, 3))
                   0: return -32768;
                   1: return 32767;
                   2: return 0;
                   default: return -1;
               endcase
            default: return $urandom_range(0, 8191) - 4096;
        endcase
    endfunction

    function automatic int rand_trig();
        if ($urandom_range(0, 3) == 0) return $urandom_range(0, 65535) - 32768;
        return $urandom_range(0, 32768) - 16384;
    endfunction

    function automatic int rand_distance();
        if ($urandom_range(0, 2) == 0) return $urandom_range(0, 65535) - 32768;
        return $urandom_range(1, 400);
    endfunction

    task automatic test_reset_view();
        send_xyz(0, 0, 0);
        send_xyz(32767, 32767, 32767);
        send_xyz(-32768, -32768, -32768);
        send_xyz(-32768, 32767, 0);
        send_xyz(32767, -32768, -1);
        send_xyz(1, -1, 1);
        send_xyz(10, 20, 30);
    endtask

    task automatic test_zero_depth();
        write_view(0, 16384, 0, 16384, 10, 250, 1023, 0);
        send_xyz(0, 0, 10);
        send_xyz(0, 0, 11);
        write_view(16384, -16384, 16384, -16384, 0, -32768, 0, 1023);
        send_xyz(0, 0, 0);
        send_xyz(5, 5, 0);
    endtask

    task automatic test_extreme_views();
        write_view(-16384, 16384, -16384, 16384, -32768, 32767, 1023, 1023);
        send_xyz(32767, -32768, 32767);
        send_xyz(-32768, 32767, -32768);
        send_xyz(1, 1, 1);
        write_view(32767, -32768, 32767, -32768, 32767, -32768, 0, 0);
        send_xyz(32767, 32767, 32767);
        send_xyz(-32768, -32768, 1);
        send_xyz(0, 0, -1);
        write_view(-32768, -32768, -32768, -32768, 1, 1, 512, 511);
        send_xyz(-32768, -32768, -32768);
        send_xyz(100, -100, 0);
    endtask

    task automatic test_random_views();
        int ed;
        bit zero_mix;
        for (int phase = 0; phase < 14; phase++) begin
            zero_mix = (phase % 4 == 3);
            ed = rand_distance();
            if (zero_mix)
                write_view(rand_trig(), rand_trig(), 0, 16384, ed, rand_distance(),
                           $urandom_range(0, 1023), $urandom_range(0, 1023));
            else
                write_view(rand_trig(), rand_trig(), rand_trig(), rand_trig(), ed,
                           rand_distance(), $urandom_range(0, 1023),
                           $urandom_range(0, 1023));
            for (int n = 0; n < 91; n++) begin
                if (zero_mix && $urandom_range(0, 2) == 0)
                    send_xyz(rand_coord(), rand_coord(), ed);
                else
                    send_xyz(rand_coord(), rand_coord(), rand_coord());
            end
        end
    endtask

    task automatic test_streaming();
        idle_on = 1'b0;
        write_view(rand_trig(), rand_trig(), rand_trig(), rand_trig(), rand_distance(),
                   rand_distance(), $urandom_range(0, 1023), $urandom_range(0, 1023));
        for (int n = 0; n < 150; n++)
            send_xyz(rand_coord(), rand_coord(), rand_coord());
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        m_ready = 1'b0;
        cfg_we = 1'b0;
        cfg_idx = '0;
        cfg_wdata = '0;
        mismatch_count = 0;
        idle_cycles = 0;
        stall_left = 0;
        idle_on = 1'b1;
        view.sin_theta = pvp_pkg::RST_SIN_THETA;
        view.cos_theta = pvp_pkg::RST_COS_THETA;
        view.sin_phi = pvp_pkg::RST_SIN_PHI;
        view.cos_phi = pvp_pkg::RST_COS_PHI;
        view.eye_distance = pvp_pkg::RST_EYE_DISTANCE;
        view.screen_distance = pvp_pkg::RST_SCREEN_DISTANCE;
        view.origin_x = pvp_pkg::RST_ORIGIN_X;
        view.origin_y = pvp_pkg::RST_ORIGIN_Y;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_reset_view();
        test_zero_depth();
        test_extreme_views();
        test_random_views();
        test_streaming();
        drain_pipeline();

        if (mismatch_count == 0 && expected_screen.size() == 0)
            $display("[perspective_vertex_projector_unit] OK");
        else
            $display("[perspective_vertex_projector_unit] ERROR");
        $finish;
    end
endmodule

>>> files.f
+incdir+rtl
rtl/pvp_pkg.sv
rtl/pvp_eye.sv
rtl/pvp_div.sv
rtl/perspective_vertex_projector_unit.sv
dv/perspective_vertex_projector_unit_tb.sv
